// File: rtl/core/depth_to_point_cloud_macros.svh
// Assertion helpers for the depth to point cloud block.
`ifndef DEPTH_TO_POINT_CLOUD_MACROS_SVH
`define DEPTH_TO_POINT_CLOUD_MACROS_SVH

// Property checked at every clock edge outside reset.
`define D2PC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define D2PC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/d2pc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package d2pc_pkg;

  localparam int DEPTH_W     = 24;
  localparam int COLOR_W     = 8;
  localparam int COORD_W     = 32;
  localparam int STRIDE_W    = 8;
  localparam int INV_W       = 32;
  localparam int CENTER_W    = 17;
  localparam int APB_DW      = 32;
  localparam int APB_AW      = 5;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    REG_SAMPLE_STRIDE = 3'd0,
    REG_MAX_DEPTH     = 3'd1,
    REG_KEEP_SKY      = 3'd2,
    REG_INV_FX        = 3'd3,
    REG_INV_FY        = 3'd4,
    REG_CENTER_X      = 3'd5,
    REG_CENTER_Y      = 3'd6
  } reg_idx_t;

  localparam logic [STRIDE_W-1:0] RST_STRIDE    = 8'd4;
  localparam logic [DEPTH_W-1:0]  RST_MAX_DEPTH = 24'd51200;
  localparam logic [INV_W-1:0]    RST_INV_F     = 32'd2236962;
  localparam logic [CENTER_W-1:0] RST_CENTER_X  = 17'd15352;
  localparam logic [CENTER_W-1:0] RST_CENTER_Y  = 17'd8632;

  typedef struct packed {
    logic [STRIDE_W-1:0] sample_stride;
    logic [DEPTH_W-1:0]  max_depth_limit;
    logic                keep_sky;
    logic [INV_W-1:0]    inv_focal_x;
    logic [INV_W-1:0]    inv_focal_y;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
  } cfg_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] z;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } pix_t;

  // Advance a stride phase; a zero stride behaves as one, and a phase left
  // above a newly written stride wraps to zero.
  function automatic logic [STRIDE_W-1:0] next_phase(input logic [STRIDE_W-1:0] phase,
                                                     input logic [STRIDE_W-1:0] stride);
    logic [STRIDE_W:0] s;
    logic [STRIDE_W:0] n;
    s = (stride == '0) ? (STRIDE_W+1)'(1) : {1'b0, stride};
    n = {1'b0, phase} + (STRIDE_W+1)'(1);
    return (n >= s) ? '0 : n[STRIDE_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/d2pc_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
module d2pc_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [d2pc_pkg::APB_AW-1:0]   paddr,
  input  wire logic [d2pc_pkg::APB_DW-1:0]   pwdata,
  output logic      [d2pc_pkg::APB_DW-1:0]   prdata,
  output logic                               pready,
  output d2pc_pkg::cfg_t                     cfg
);

  d2pc_pkg::cfg_t   cfg_r;
  d2pc_pkg::reg_idx_t idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = d2pc_pkg::reg_idx_t'(paddr[d2pc_pkg::APB_AW-1:2]);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_stride   <= d2pc_pkg::RST_STRIDE;
      cfg_r.max_depth_limit <= d2pc_pkg::RST_MAX_DEPTH;
      cfg_r.keep_sky        <= 1'b0;
      cfg_r.inv_focal_x     <= d2pc_pkg::RST_INV_F;
      cfg_r.inv_focal_y     <= d2pc_pkg::RST_INV_F;
      cfg_r.center_x        <= d2pc_pkg::RST_CENTER_X;
      cfg_r.center_y        <= d2pc_pkg::RST_CENTER_Y;
    end else if (wr_en) begin
      case (idx)
        d2pc_pkg::REG_SAMPLE_STRIDE: begin
          cfg_r.sample_stride <= pwdata[d2pc_pkg::STRIDE_W-1:0];
        end
        d2pc_pkg::REG_MAX_DEPTH: begin
          cfg_r.max_depth_limit <= pwdata[d2pc_pkg::DEPTH_W-1:0];
        end
        d2pc_pkg::REG_KEEP_SKY: begin
          cfg_r.keep_sky <= pwdata[0];
        end
        d2pc_pkg::REG_INV_FX: begin
          cfg_r.inv_focal_x <= pwdata[d2pc_pkg::INV_W-1:0];
        end
        d2pc_pkg::REG_INV_FY: begin
          cfg_r.inv_focal_y <= pwdata[d2pc_pkg::INV_W-1:0];
        end
        d2pc_pkg::REG_CENTER_X: begin
          cfg_r.center_x <= pwdata[d2pc_pkg::CENTER_W-1:0];
        end
        d2pc_pkg::REG_CENTER_Y: begin
          cfg_r.center_y <= pwdata[d2pc_pkg::CENTER_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      d2pc_pkg::REG_SAMPLE_STRIDE: prdata = d2pc_pkg::APB_DW'(cfg_r.sample_stride);
      d2pc_pkg::REG_MAX_DEPTH:     prdata = d2pc_pkg::APB_DW'(cfg_r.max_depth_limit);
      d2pc_pkg::REG_KEEP_SKY:      prdata = d2pc_pkg::APB_DW'(cfg_r.keep_sky);
      d2pc_pkg::REG_INV_FX:        prdata = d2pc_pkg::APB_DW'(cfg_r.inv_focal_x);
      d2pc_pkg::REG_INV_FY:        prdata = d2pc_pkg::APB_DW'(cfg_r.inv_focal_y);
      d2pc_pkg::REG_CENTER_X:      prdata = d2pc_pkg::APB_DW'(cfg_r.center_x);
      d2pc_pkg::REG_CENTER_Y:      prdata = d2pc_pkg::APB_DW'(cfg_r.center_y);
      default:                     prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/d2pc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module d2pc_front #(
  parameter int MAX_DIM = 8192
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [d2pc_pkg::DEPTH_W-1:0]      in_depth_value,
  input  wire logic                              in_depth_finite,
  input  wire logic [d2pc_pkg::COLOR_W-1:0]      in_blue,
  input  wire logic [d2pc_pkg::COLOR_W-1:0]      in_green,
  input  wire logic [d2pc_pkg::COLOR_W-1:0]      in_red,
  input  wire logic                              in_sky_flag,
  input  wire logic                              in_frame_start,
  input  wire logic                              in_line_end,
  input  wire d2pc_pkg::cfg_t                    cfg,
  input  wire logic                              q_full,
  output logic                                   q_push,
  output logic                                   q_neg_x,
  output logic [((($clog2(MAX_DIM) + 4) > d2pc_pkg::CENTER_W) ?
                ($clog2(MAX_DIM) + 4) : d2pc_pkg::CENTER_W)-1:0] q_mag_x,
  output logic                                   q_neg_y,
  output logic [((($clog2(MAX_DIM) + 4) > d2pc_pkg::CENTER_W) ?
                ($clog2(MAX_DIM) + 4) : d2pc_pkg::CENTER_W)-1:0] q_mag_y,
  output d2pc_pkg::pix_t                         q_pix
);

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int MAG_W = ((CNT_W + 4) > d2pc_pkg::CENTER_W) ? (CNT_W + 4) : d2pc_pkg::CENTER_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIM - 1);

  logic [CNT_W-1:0]              col_r, col_nxt, row_r, row_nxt;
  logic [d2pc_pkg::STRIDE_W-1:0] cph_r, cph_nxt, rph_r, rph_nxt;
  logic [CNT_W-1:0]              col_cur, row_cur;
  logic [d2pc_pkg::STRIDE_W-1:0] cph_cur, rph_cur;
  logic                          accept, keep;
  logic [MAG_W:0]                diff_x, diff_y;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // A frame start clears position and phases before this pixel is used.
  assign col_cur = in_frame_start ? '0 : col_r;
  assign row_cur = in_frame_start ? '0 : row_r;
  assign cph_cur = in_frame_start ? '0 : cph_r;
  assign rph_cur = in_frame_start ? '0 : rph_r;

  assign keep = (cph_cur == '0) && (rph_cur == '0) && in_depth_finite &&
                (in_depth_value != '0) && (in_depth_value <= cfg.max_depth_limit) &&
                !(in_sky_flag && !cfg.keep_sky);

  // Offsets from the principal point in Q.4 pixels, split into sign and magnitude.
  assign diff_x = (MAG_W+1)'({col_cur, 4'b0000}) - (MAG_W+1)'(cfg.center_x);
  assign diff_y = (MAG_W+1)'({row_cur, 4'b0000}) - (MAG_W+1)'(cfg.center_y);

  assign q_push  = accept && keep;
  assign q_neg_x = diff_x[MAG_W];
  assign q_neg_y = diff_y[MAG_W];
  assign q_mag_x = diff_x[MAG_W] ? MAG_W'(-diff_x) : diff_x[MAG_W-1:0];
  assign q_mag_y = diff_y[MAG_W] ? MAG_W'(-diff_y) : diff_y[MAG_W-1:0];

  assign q_pix.z     = in_depth_value;
  assign q_pix.red   = in_red;
  assign q_pix.green = in_green;
  assign q_pix.blue  = in_blue;

  always_comb begin
    col_nxt = col_cur;
    row_nxt = row_cur;
    cph_nxt = cph_cur;
    rph_nxt = rph_cur;
    if (in_line_end) begin
      col_nxt = '0;
      cph_nxt = '0;
      row_nxt = (row_cur >= CNT_MAX) ? CNT_MAX : row_cur + CNT_W'(1);
      rph_nxt = d2pc_pkg::next_phase(rph_cur, cfg.sample_stride);
    end else begin
      col_nxt = (col_cur >= CNT_MAX) ? CNT_MAX : col_cur + CNT_W'(1);
      cph_nxt = d2pc_pkg::next_phase(cph_cur, cfg.sample_stride);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      cph_r <= '0;
      rph_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      cph_r <= cph_nxt;
      rph_r <= rph_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/d2pc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module d2pc_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  not_empty
);

  localparam int AW = $clog2(d2pc_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(d2pc_pkg::QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [d2pc_pkg::QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CW'(d2pc_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rdata     = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/d2pc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module d2pc_back #(
  parameter int MAX_DIM = 8192
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_valid,
  output logic                                   q_pop,
  input  wire logic                              q_neg_x,
  input  wire logic [((($clog2(MAX_DIM) + 4) > d2pc_pkg::CENTER_W) ?
                     ($clog2(MAX_DIM) + 4) : d2pc_pkg::CENTER_W)-1:0] q_mag_x,
  input  wire logic                              q_neg_y,
  input  wire logic [((($clog2(MAX_DIM) + 4) > d2pc_pkg::CENTER_W) ?
                     ($clog2(MAX_DIM) + 4) : d2pc_pkg::CENTER_W)-1:0] q_mag_y,
  input  wire d2pc_pkg::pix_t                    q_pix,
  input  wire logic [d2pc_pkg::INV_W-1:0]        inv_x,
  input  wire logic [d2pc_pkg::INV_W-1:0]        inv_y,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [d2pc_pkg::COORD_W-1:0]    out_point_x,
  output logic signed [d2pc_pkg::COORD_W-1:0]    out_point_y,
  output logic [d2pc_pkg::DEPTH_W-1:0]           out_point_z,
  output logic [d2pc_pkg::COLOR_W-1:0]           out_red,
  output logic [d2pc_pkg::COLOR_W-1:0]           out_green,
  output logic [d2pc_pkg::COLOR_W-1:0]           out_blue
);

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int MAG_W = ((CNT_W + 4) > d2pc_pkg::CENTER_W) ? (CNT_W + 4) : d2pc_pkg::CENTER_W;
  localparam int P_W   = MAG_W + d2pc_pkg::DEPTH_W;
  localparam int PH_W  = P_W - 32;
  localparam int HI_W  = PH_W + d2pc_pkg::INV_W;
  localparam int SUM_W = HI_W + 1;
  localparam int Q_W   = SUM_W - 4;

  logic                 adv;
  logic                 s1_valid_r, s2_valid_r, out_valid_r;
  logic [P_W-1:0]       px, py, s1_px_r, s1_py_r;
  logic                 s1_neg_x_r, s1_neg_y_r, s2_neg_x_r, s2_neg_y_r;
  d2pc_pkg::pix_t       s1_pix_r, s2_pix_r, out_pix_r;
  logic [HI_W-1:0]      hi_x, hi_y, s2_hi_x_r, s2_hi_y_r;
  logic [63:0]          lo_x, lo_y;
  logic [31:0]          s2_lo_x_r, s2_lo_y_r;
  logic [SUM_W-1:0]     sum_x, sum_y;
  logic signed [d2pc_pkg::COORD_W-1:0] coord_x, coord_y, out_x_r, out_y_r;

  // Apply the sign to a truncated magnitude and clamp to the signed 32-bit range.
  function automatic logic signed [d2pc_pkg::COORD_W-1:0] sat_coord(input logic [Q_W-1:0] q,
                                                                    input logic neg);
    logic big;
    big = |q[Q_W-1:31];
    if (neg) begin
      return big ? 32'sh8000_0000 : $signed(32'd0 - q[31:0]);
    end
    return big ? 32'sh7FFF_FFFF : $signed(q[31:0]);
  endfunction

  // The whole pipeline moves whenever the output register can take a new item.
  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && q_valid;

  assign px = P_W'(q_mag_x) * P_W'(q_pix.z);
  assign py = P_W'(q_mag_y) * P_W'(q_pix.z);

  // The 32-bit reciprocal is applied to the upper and lower halves separately.
  assign hi_x = HI_W'(s1_px_r[P_W-1:32]) * HI_W'(inv_x);
  assign hi_y = HI_W'(s1_py_r[P_W-1:32]) * HI_W'(inv_y);
  assign lo_x = 64'(s1_px_r[31:0]) * 64'(inv_x);
  assign lo_y = 64'(s1_py_r[31:0]) * 64'(inv_y);

  assign sum_x = SUM_W'(s2_hi_x_r) + SUM_W'(s2_lo_x_r);
  assign sum_y = SUM_W'(s2_hi_y_r) + SUM_W'(s2_lo_y_r);
  assign coord_x = sat_coord(sum_x[SUM_W-1:4], s2_neg_x_r);
  assign coord_y = sat_coord(sum_y[SUM_W-1:4], s2_neg_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= q_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_px_r    <= px;
      s1_py_r    <= py;
      s1_neg_x_r <= q_neg_x;
      s1_neg_y_r <= q_neg_y;
      s1_pix_r   <= q_pix;
      s2_hi_x_r  <= hi_x;
      s2_hi_y_r  <= hi_y;
      s2_lo_x_r  <= lo_x[63:32];
      s2_lo_y_r  <= lo_y[63:32];
      s2_neg_x_r <= s1_neg_x_r;
      s2_neg_y_r <= s1_neg_y_r;
      s2_pix_r   <= s1_pix_r;
      out_x_r    <= coord_x;
      out_y_r    <= coord_y;
      out_pix_r  <= s2_pix_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_point_x = out_x_r;
  assign out_point_y = out_y_r;
  assign out_point_z = out_pix_r.z;
  assign out_red     = out_pix_r.red;
  assign out_green   = out_pix_r.green;
  assign out_blue    = out_pix_r.blue;

endmodule
`default_nettype wire

// File: rtl/core/depth_to_point_cloud.sv
`timescale 1ns / 1ps
`default_nettype none
// Pinhole back-projection of a raster depth stream into colored 3D points.
// Input channel: one pixel per item (depth, finite flag, color, sky flag,
// frame-start and line-end marks), accepted when in_valid is high and
// in_stall low. Every accepted item is kept or dropped by the stride,
// depth and sky tests; a kept pixel yields one point on the out_ channel.
// Output channel: a point is taken when out_valid is high and out_stall low.
// Throughput is one item per clock while in_stall is low. A kept pixel is
// written into the queue at the edge that accepts it, then passes through
// the depth multiply, the reciprocal multiply, and the sum and clamp into
// the output register, which raises out_valid.
// A four-entry queue sits between the pixel counters and the multiplier
// pipeline; while out_stall holds, the pipeline freezes, the queue fills and
// in_stall rises once it is full. Dropped pixels never enter the queue.
// Reset (rst_n low, synchronous) loads the register defaults, clears the
// column and row counters and phases, and empties the queue and pipeline.
// Registers are written through the APB port at byte address 4*index and
// are to be changed only while no kept pixel is still in flight.
module depth_to_point_cloud #(
  parameter int MAX_DIM = 8192
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [d2pc_pkg::DEPTH_W-1:0]      in_depth_value,
  input  wire logic                              in_depth_finite,
  input  wire logic [d2pc_pkg::COLOR_W-1:0]      in_blue,
  input  wire logic [d2pc_pkg::COLOR_W-1:0]      in_green,
  input  wire logic [d2pc_pkg::COLOR_W-1:0]      in_red,
  input  wire logic                              in_sky_flag,
  input  wire logic                              in_frame_start,
  input  wire logic                              in_line_end,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [d2pc_pkg::COORD_W-1:0]    out_point_x,
  output logic signed [d2pc_pkg::COORD_W-1:0]    out_point_y,
  output logic [d2pc_pkg::DEPTH_W-1:0]           out_point_z,
  output logic [d2pc_pkg::COLOR_W-1:0]           out_red,
  output logic [d2pc_pkg::COLOR_W-1:0]           out_green,
  output logic [d2pc_pkg::COLOR_W-1:0]           out_blue,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [d2pc_pkg::APB_AW-1:0]       paddr,
  input  wire logic [d2pc_pkg::APB_DW-1:0]       pwdata,
  output logic      [d2pc_pkg::APB_DW-1:0]       prdata,
  output logic                                   pready
);

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int MAG_W = ((CNT_W + 4) > d2pc_pkg::CENTER_W) ? (CNT_W + 4) : d2pc_pkg::CENTER_W;
  localparam int QW    = 2 * (MAG_W + 1) + $bits(d2pc_pkg::pix_t);

  d2pc_pkg::cfg_t   cfg;
  logic             q_full, q_push, q_pop, q_valid;
  logic             f_neg_x, f_neg_y, b_neg_x, b_neg_y;
  logic [MAG_W-1:0] f_mag_x, f_mag_y, b_mag_x, b_mag_y;
  d2pc_pkg::pix_t   f_pix, b_pix;
  logic [QW-1:0]    q_wdata, q_rdata;

  d2pc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  d2pc_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_depth_value  (in_depth_value),
    .in_depth_finite (in_depth_finite),
    .in_blue         (in_blue),
    .in_green        (in_green),
    .in_red          (in_red),
    .in_sky_flag     (in_sky_flag),
    .in_frame_start  (in_frame_start),
    .in_line_end     (in_line_end),
    .cfg             (cfg),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_neg_x         (f_neg_x),
    .q_mag_x         (f_mag_x),
    .q_neg_y         (f_neg_y),
    .q_mag_y         (f_mag_y),
    .q_pix           (f_pix)
  );

  assign q_wdata = {f_neg_x, f_mag_x, f_neg_y, f_mag_y, f_pix};

  d2pc_fifo #(.WIDTH(QW)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_valid)
  );

  assign {b_neg_x, b_mag_x, b_neg_y, b_mag_y, b_pix} = q_rdata;

  d2pc_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_neg_x     (b_neg_x),
    .q_mag_x     (b_mag_x),
    .q_neg_y     (b_neg_y),
    .q_mag_y     (b_mag_y),
    .q_pix       (b_pix),
    .inv_x       (cfg.inv_focal_x),
    .inv_y       (cfg.inv_focal_y),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_point_x (out_point_x),
    .out_point_y (out_point_y),
    .out_point_z (out_point_z),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue)
  );

endmodule
`default_nettype wire

// File: rtl/core/d2pc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "depth_to_point_cloud_macros.svh"
module d2pc_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [d2pc_pkg::DEPTH_W-1:0] out_point_z
);

  // A point waiting at the output is not withdrawn.
  `D2PC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "point dropped under stall")

  // Points with zero depth are always rejected, so none may reach the output.
  `D2PC_ASSERT(a_depth_nonzero, clk, rst_n, out_valid |-> (out_point_z != '0), "point with zero depth")

  // Leaving reset, the queue and pipeline are empty.
  `D2PC_ASSERT(a_reset_empty, clk, rst_n, $rose(rst_n) |-> (!out_valid && !in_stall), "not empty after reset")

endmodule

bind depth_to_point_cloud d2pc_checker u_d2pc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_point_z (out_point_z)
);
`default_nettype wire

// File: dv/depth_to_point_cloud_test.sv
`timescale 1ns / 1ps
module depth_to_point_cloud_test;
  import d2pc_pkg::*;

  localparam int MAX_DIM = 8192;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1800;
  localparam logic [2:0] UNMAPPED_REG = 3'd7;

  typedef struct {
    logic [DEPTH_W-1:0] depth;
    logic               finite;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
    logic               sky;
    logic               frame_start;
    logic               line_end;
  } pixel_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [DEPTH_W-1:0]        z;
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        blue;
  } point_t;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_PREDICTED,
    ROW_NO_POINT,
    ROW_FIXED_POINT
  } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  index;
    logic [31:0] value;
    pixel_t      pix;
    point_t      pt;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [DEPTH_W-1:0] in_depth_value = '0;
  logic in_depth_finite = 1'b0;
  logic [COLOR_W-1:0] in_blue = '0;
  logic [COLOR_W-1:0] in_green = '0;
  logic [COLOR_W-1:0] in_red = '0;
  logic in_sky_flag = 1'b0;
  logic in_frame_start = 1'b0;
  logic in_line_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [COORD_W-1:0] out_point_x;
  logic signed [COORD_W-1:0] out_point_y;
  logic [DEPTH_W-1:0] out_point_z;
  logic [COLOR_W-1:0] out_red;
  logic [COLOR_W-1:0] out_green;
  logic [COLOR_W-1:0] out_blue;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  always #2 clk = ~clk;

  depth_to_point_cloud #(.MAX_DIM(MAX_DIM)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_depth_value(in_depth_value), .in_depth_finite(in_depth_finite),
    .in_blue(in_blue), .in_green(in_green), .in_red(in_red),
    .in_sky_flag(in_sky_flag), .in_frame_start(in_frame_start), .in_line_end(in_line_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_point_x(out_point_x), .out_point_y(out_point_y), .out_point_z(out_point_z),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow of the registers and the raster position of the next pixel.
  cfg_t shadow_cfg;
  logic [12:0] col_pos;
  logic [12:0] row_pos;
  logic [STRIDE_W-1:0] col_phase;
  logic [STRIDE_W-1:0] row_phase;

  point_t pending_points[$];
  stim_row_t rows[$];
  int mismatches = 0;
  int gap_mode = 1;
  int stall_mode = 1;
  int stall_left = 0;

  function automatic void queue_point(input point_t pt);
    pending_points.insert(pending_points.size(), pt);
  endfunction

  function automatic void add_row(input stim_row_t row);
    rows.insert(rows.size(), row);
  endfunction

  function automatic logic [STRIDE_W-1:0] advance_phase(input logic [STRIDE_W-1:0] phase);
    logic [STRIDE_W:0] period;
    logic [STRIDE_W:0] bumped;
    period = (shadow_cfg.sample_stride == '0) ? (STRIDE_W+1)'(1) :
             {1'b0, shadow_cfg.sample_stride};
    bumped = {1'b0, phase} + 1'b1;
    return (bumped >= period) ? '0 : bumped[STRIDE_W-1:0];
  endfunction

  function automatic logic [12:0] advance_count(input logic [12:0] count);
    return (count >= 13'(MAX_DIM - 1)) ? 13'(MAX_DIM - 1) : count + 13'd1;
  endfunction

  // Offset from the principal point in Q.4, times depth and reciprocal focal
  // length, gives Q.44; dropping 36 bits of the magnitude truncates toward zero.
  function automatic logic signed [COORD_W-1:0] backproject_axis(
      input logic [12:0] pos, input logic [CENTER_W-1:0] center,
      input logic [DEPTH_W-1:0] z, input logic [INV_W-1:0] inv);
    logic signed [18:0] offset;
    logic [17:0] magnitude;
    logic [127:0] product;
    logic [127:0] scaled;
    offset = $signed({2'b00, pos, 4'b0000}) - $signed({2'b00, center});
    magnitude = offset[18] ? 18'(-offset) : 18'(offset);
    product = 128'(magnitude) * 128'(z) * 128'(inv);
    scaled = product >> 36;
    if (offset[18]) begin
      return (scaled >= 128'h8000_0000) ? 32'h8000_0000 : -scaled[31:0];
    end
    return (scaled > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : scaled[31:0];
  endfunction

  task automatic project_pixel(input pixel_t pix, output bit kept, output point_t pt);
    if (pix.frame_start) begin
      col_pos = '0;
      row_pos = '0;
      col_phase = '0;
      row_phase = '0;
    end
    kept = col_phase == '0 && row_phase == '0 && pix.finite && pix.depth != '0 &&
           pix.depth <= shadow_cfg.max_depth_limit && !(pix.sky && !shadow_cfg.keep_sky);
    pt.x = backproject_axis(col_pos, shadow_cfg.center_x, pix.depth, shadow_cfg.inv_focal_x);
    pt.y = backproject_axis(row_pos, shadow_cfg.center_y, pix.depth, shadow_cfg.inv_focal_y);
    pt.z = pix.depth;
    pt.red = pix.red;
    pt.green = pix.green;
    pt.blue = pix.blue;
    if (pix.line_end) begin
      col_pos = '0;
      col_phase = '0;
      row_pos = advance_count(row_pos);
      row_phase = advance_phase(row_phase);
    end else begin
      col_pos = advance_count(col_pos);
      col_phase = advance_phase(col_phase);
    end
  endtask

  function automatic int burst_length();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 20);
  endfunction

  function automatic int idle_gap();
    if (gap_mode == 0 || $urandom_range(0, 99) >= (gap_mode == 1 ? 20 : 50)) begin
      return 0;
    end
    return burst_length();
  endfunction

  // Waits for all points in flight, then for the pipeline to empty.
  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_points.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_points.size() != 0) begin
      mismatches += pending_points.size();
      $error("%0d expected points never arrived", pending_points.size());
      pending_points.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] index, input logic [31:0] value);
    settle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      REG_SAMPLE_STRIDE: shadow_cfg.sample_stride = value[STRIDE_W-1:0];
      REG_MAX_DEPTH:     shadow_cfg.max_depth_limit = value[DEPTH_W-1:0];
      REG_KEEP_SKY:      shadow_cfg.keep_sky = value[0];
      REG_INV_FX:        shadow_cfg.inv_focal_x = value[INV_W-1:0];
      REG_INV_FY:        shadow_cfg.inv_focal_y = value[INV_W-1:0];
      REG_CENTER_X:      shadow_cfg.center_x = value[CENTER_W-1:0];
      REG_CENTER_Y:      shadow_cfg.center_y = value[CENTER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_pixel(input pixel_t pix, output bit kept, output point_t pt);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_depth_value <= pix.depth;
    in_depth_finite <= pix.finite;
    in_blue <= pix.blue;
    in_green <= pix.green;
    in_red <= pix.red;
    in_sky_flag <= pix.sky;
    in_frame_start <= pix.frame_start;
    in_line_end <= pix.line_end;
    do @(posedge clk); while (in_stall);
    project_pixel(pix, kept, pt);
  endtask

  task automatic stream_pixel(input pixel_t pix);
    bit kept;
    point_t pt;
    send_pixel(pix, kept, pt);
    if (kept) queue_point(pt);
  endtask

  function automatic pixel_t make_pixel(input logic [DEPTH_W-1:0] depth, input logic finite,
      input logic sky, input logic frame_start, input logic line_end,
      input logic [COLOR_W-1:0] red, input logic [COLOR_W-1:0] green,
      input logic [COLOR_W-1:0] blue);
    pixel_t pix;
    pix.depth = depth;
    pix.finite = finite;
    pix.sky = sky;
    pix.frame_start = frame_start;
    pix.line_end = line_end;
    pix.red = red;
    pix.green = green;
    pix.blue = blue;
    return pix;
  endfunction

  function automatic point_t make_point(input logic signed [COORD_W-1:0] x,
      input logic signed [COORD_W-1:0] y, input logic [DEPTH_W-1:0] z,
      input logic [COLOR_W-1:0] red, input logic [COLOR_W-1:0] green,
      input logic [COLOR_W-1:0] blue);
    point_t pt;
    pt.x = x;
    pt.y = y;
    pt.z = z;
    pt.red = red;
    pt.green = green;
    pt.blue = blue;
    return pt;
  endfunction

  function automatic stim_row_t write_row(input logic [2:0] index, input logic [31:0] value);
    stim_row_t row;
    row.kind = ROW_WRITE;
    row.index = index;
    row.value = value;
    return row;
  endfunction

  function automatic stim_row_t pixel_row(input row_kind_t kind, input pixel_t pix);
    stim_row_t row;
    row.kind = kind;
    row.pix = pix;
    return row;
  endfunction

  function automatic stim_row_t fixed_row(input pixel_t pix, input point_t pt);
    stim_row_t row;
    row.kind = ROW_FIXED_POINT;
    row.pix = pix;
    row.pt = pt;
    return row;
  endfunction

  // Sets random upper bits on a narrow register write now and then.
  function automatic logic [31:0] with_junk(input logic [31:0] value, input int width);
    logic [31:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? ($urandom() << width) : 32'd0;
    return value | junk;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t pix;
    logic [DEPTH_W-1:0] lim;
    lim = (shadow_cfg.max_depth_limit == '0) ? 24'd1 : shadow_cfg.max_depth_limit;
    case ($urandom_range(0, 9))
      7: pix.depth = '0;
      8: pix.depth = (lim == 24'hFF_FFFF) ? lim : 24'($urandom_range(lim + 1, 24'hFF_FFFF));
      9: pix.depth = 24'($urandom());
      default: pix.depth = 24'($urandom_range(1, lim));
    endcase
    pix.finite = $urandom_range(0, 9) != 0;
    pix.sky = $urandom_range(0, 3) == 0;
    pix.red = 8'($urandom());
    pix.green = 8'($urandom());
    pix.blue = 8'($urandom());
    pix.frame_start = 1'b0;
    pix.line_end = 1'b0;
    return pix;
  endfunction

  task automatic randomize_registers();
    logic [31:0] value;
    if ($urandom_range(0, 9) < 6) begin
      case ($urandom_range(0, 9))
        6, 7: value = $urandom_range(5, 16);
        8: value = $urandom_range(0, 1) ? 32'd255 : 32'd0;
        9: value = $urandom_range(0, 255);
        default: value = $urandom_range(1, 4);
      endcase
      write_register(REG_SAMPLE_STRIDE, with_junk(value, STRIDE_W));
    end
    if ($urandom_range(0, 9) < 6) begin
      case ($urandom_range(0, 9))
        6: value = 32'd1;
        7: value = 32'hFF_FFFF;
        8, 9: value = $urandom() & 32'hFF_FFFF;
        default: value = $urandom_range(256, 25600);
      endcase
      write_register(REG_MAX_DEPTH, with_junk(value, DEPTH_W));
    end
    if ($urandom_range(0, 9) < 6) begin
      write_register(REG_KEEP_SKY, with_junk($urandom_range(0, 1), 1));
    end
    for (int axis = 0; axis < 2; axis++) begin
      if ($urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 9))
          6: value = 32'd0;
          7: value = 32'hFFFF_FFFF;
          8, 9: value = $urandom();
          default: value = $urandom_range(2147483, 21474836);
        endcase
        write_register(axis == 0 ? REG_INV_FX : REG_INV_FY, value);
      end
      if ($urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 9))
          6: value = 32'd0;
          7: value = 32'h1_FFFF;
          8, 9: value = $urandom() & 32'h1_FFFF;
          default: value = $urandom_range(0, 640);
        endcase
        write_register(axis == 0 ? REG_CENTER_X : REG_CENTER_Y, with_junk(value, CENTER_W));
      end
    end
  endtask

  // Result side stalls in bursts, mostly short ones.
  always @(posedge clk) begin
    if (stall_mode == 0) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < (stall_mode == 1 ? 15 : 40)) begin
      out_stall <= 1'b1;
      stall_left <= burst_length() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void report_field(input string field, input longint expected,
                                       input longint actual);
    mismatches++;
    $error("%s: expected %0d, got %0d", field, expected, actual);
  endfunction

  always @(posedge clk) begin : check_points
    point_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        mismatches++;
        $error("point arrived with none expected");
      end else begin
        want = pending_points.pop_front();
        if (out_point_x !== want.x) report_field("point_x", want.x, out_point_x);
        if (out_point_y !== want.y) report_field("point_y", want.y, out_point_y);
        if (out_point_z !== want.z) report_field("point_z", want.z, out_point_z);
        if (out_red !== want.red) report_field("out_red", want.red, out_red);
        if (out_green !== want.green) report_field("out_green", want.green, out_green);
        if (out_blue !== want.blue) report_field("out_blue", want.blue, out_blue);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    pixel_t pix;
    point_t pt;
    bit kept;
    int sent;
    int width;
    int height;
    bit noisy;

    shadow_cfg.sample_stride = RST_STRIDE;
    shadow_cfg.max_depth_limit = RST_MAX_DEPTH;
    shadow_cfg.keep_sky = 1'b0;
    shadow_cfg.inv_focal_x = RST_INV_F;
    shadow_cfg.inv_focal_y = RST_INV_F;
    shadow_cfg.center_x = RST_CENTER_X;
    shadow_cfg.center_y = RST_CENTER_Y;
    col_pos = '0;
    row_pos = '0;
    col_phase = '0;
    row_phase = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With the reset intrinsics, one meter at the top left corner lands about
    // half a meter left of and a quarter meter above the axis.
    add_row(fixed_row(make_pixel(24'd256, 1, 0, 1, 0, 8'h11, 8'h22, 8'h33),
                      make_point(-32'sd127, -32'sd71, 24'd256, 8'h11, 8'h22, 8'h33)));
    add_row(pixel_row(ROW_NO_POINT, make_pixel(24'd256, 1, 0, 0, 0, 8'h01, 8'h02, 8'h03)));
    add_row(write_row(REG_SAMPLE_STRIDE, 32'd1));
    add_row(pixel_row(ROW_NO_POINT, make_pixel(24'd0, 1, 0, 1, 0, 8'h44, 8'h55, 8'h66)));
    add_row(pixel_row(ROW_NO_POINT, make_pixel(24'd256, 0, 0, 0, 0, 8'h77, 8'h88, 8'h99)));
    add_row(pixel_row(ROW_NO_POINT, make_pixel(24'd51201, 1, 0, 0, 0, 8'hAA, 8'hBB, 8'hCC)));
    add_row(pixel_row(ROW_PREDICTED, make_pixel(24'd51200, 1, 0, 0, 0, 8'hDD, 8'hEE, 8'h00)));
    add_row(pixel_row(ROW_NO_POINT, make_pixel(24'd256, 1, 1, 0, 0, 8'h12, 8'h34, 8'h56)));
    add_row(write_row(REG_KEEP_SKY, 32'hFFFF_FFFF));
    add_row(pixel_row(ROW_PREDICTED, make_pixel(24'd256, 1, 1, 0, 1, 8'h9A, 8'hBC, 8'hDE)));
    add_row(write_row(REG_INV_FX, 32'd0));
    add_row(write_row(REG_INV_FY, 32'd0));
    add_row(fixed_row(make_pixel(24'd256, 1, 0, 1, 0, 8'hFF, 8'hFF, 8'hFF),
                      make_point(32'sd0, 32'sd0, 24'd256, 8'hFF, 8'hFF, 8'hFF)));
    add_row(write_row(REG_MAX_DEPTH, 32'hFFFF_FFFF));
    add_row(write_row(REG_INV_FX, 32'hFFFF_FFFF));
    add_row(write_row(REG_INV_FY, 32'hFFFF_FFFF));
    add_row(write_row(REG_CENTER_X, 32'hFFFF_FFFF));
    add_row(write_row(REG_CENTER_Y, 32'hFFFF_FFFF));
    // Far corner of the principal point with the deepest pixel clips low.
    add_row(fixed_row(make_pixel(24'hFF_FFFF, 1, 0, 1, 0, 8'h00, 8'h00, 8'h00),
                      make_point(32'h8000_0000, 32'h8000_0000, 24'hFF_FFFF,
                                 8'h00, 8'h00, 8'h00)));
    add_row(write_row(REG_SAMPLE_STRIDE, 32'd0));
    add_row(pixel_row(ROW_PREDICTED, make_pixel(24'd1, 1, 0, 0, 1, 8'h0F, 8'hF0, 8'h5A)));
    add_row(pixel_row(ROW_PREDICTED, make_pixel(24'd1, 1, 0, 0, 0, 8'hA5, 8'h3C, 8'hC3)));
    add_row(write_row(UNMAPPED_REG, 32'd5));
    add_row(pixel_row(ROW_PREDICTED, make_pixel(24'hAB_CDEF, 1, 0, 0, 0, 8'h81, 8'h42, 8'h24)));
    add_row(write_row(REG_SAMPLE_STRIDE, 32'd255));
    add_row(pixel_row(ROW_PREDICTED, make_pixel(24'd300, 1, 0, 1, 0, 8'h18, 8'h81, 8'h7E)));
    add_row(pixel_row(ROW_NO_POINT, make_pixel(24'd300, 1, 0, 0, 0, 8'hE7, 8'h66, 8'h99)));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WRITE) begin
        write_register(rows[i].index, rows[i].value);
      end else begin
        send_pixel(rows[i].pix, kept, pt);
        case (rows[i].kind)
          ROW_PREDICTED:   if (kept) queue_point(pt);
          ROW_FIXED_POINT: queue_point(rows[i].pt);
          default: ;
        endcase
      end
    end

    // Mostly well-formed frames of random content, some with scattered marks.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      randomize_registers();
      gap_mode = $urandom_range(0, 2);
      stall_mode = $urandom_range(0, 2);
      repeat ($urandom_range(1, 3)) begin
        width = $urandom_range(1, 24);
        height = $urandom_range(1, 12);
        noisy = $urandom_range(0, 4) == 0;
        for (int r = 0; r < height && sent < RANDOM_ITEMS; r++) begin
          for (int c = 0; c < width && sent < RANDOM_ITEMS; c++) begin
            pix = random_pixel();
            if (noisy) begin
              pix.frame_start = $urandom_range(0, 15) == 0;
              pix.line_end = $urandom_range(0, 7) == 0;
            end else begin
              pix.frame_start = r == 0 && c == 0;
              pix.line_end = c == width - 1;
            end
            stream_pixel(pix);
            sent++;
          end
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
